>>> src/repeating_timer_event_table_top_defines.svh
// Assertion macros shared by the timer table RTL.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef REPEATING_TIMER_EVENT_TABLE_TOP_DEFINES_SVH
`define REPEATING_TIMER_EVENT_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define RTET_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTET_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rtet_pkg.sv
// Shared types, codes and widths for the repeating timer event table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rtet_pkg;
    localparam int SLOTS_DEF     = 16;
    localparam int TIME_BITS_DEF = 48;

    localparam int ID_W       = 31;
    localparam int REP_W      = 16;
    localparam int CMD_W      = 3;
    localparam int KIND_W     = 2;
    localparam int IO_TIME_W  = 48;
    localparam int S_TDATA_W  = 192;
    localparam int M_TDATA_W  = 96;

    localparam logic [CMD_W-1:0] CMD_ADD_AT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_NOW   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_IVL   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CANCEL    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RUN_UNTIL = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RUN_FOR   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SET_TIME  = 3'd6;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd7;

    localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

    typedef logic [4:0] t_op;

    localparam t_op OP_NOP           = 5'd0;
    localparam t_op OP_LOAD          = 5'd1;
    localparam t_op OP_SUM_TV        = 5'd2;
    localparam t_op OP_SUM_CUR       = 5'd3;
    localparam t_op OP_SUM_IVL       = 5'd4;
    localparam t_op OP_SCAN_FREE     = 5'd5;
    localparam t_op OP_ADD_WR        = 5'd6;
    localparam t_op OP_RD            = 5'd7;
    localparam t_op OP_CHK_ID        = 5'd8;
    localparam t_op OP_SET_WR        = 5'd9;
    localparam t_op OP_CANCEL        = 5'd10;
    localparam t_op OP_RUN_UNTIL     = 5'd11;
    localparam t_op OP_RUN_FOR       = 5'd12;
    localparam t_op OP_PEND_CHK      = 5'd13;
    localparam t_op OP_SEL_CLR       = 5'd14;
    localparam t_op OP_SEL_CHK       = 5'd15;
    localparam t_op OP_FIRE_CALC     = 5'd16;
    localparam t_op OP_FIRE_WR       = 5'd17;
    localparam t_op OP_SET_TIME      = 5'd18;
    localparam t_op OP_CLEAR         = 5'd19;
    localparam t_op OP_EMIT_ADD_OK   = 5'd20;
    localparam t_op OP_EMIT_ADD_FULL = 5'd21;
    localparam t_op OP_EMIT_FIRE     = 5'd22;
    localparam t_op OP_EMIT_DONE     = 5'd23;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic free_hit;   // slot under the index is free
        logic last;       // index sits on the last slot
        logic match;      // slot under the index holds the wanted id
        logic found;      // a pending timer has been picked this pass
        logic out_busy;   // result register holds an item not yet taken
    } t_dp_stat;
endpackage
`default_nettype wire

>>> src/rtet_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rtet_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]      i_wdata,
    input  wire logic                  i_re,
    input  wire logic [AW-1:0]         i_raddr,
    output logic      [WIDTH-1:0]      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> src/rtet_ctrl.sv
// Controller state machine of the timer table: sequences datapath operations per command.
// Depends on rtet_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "repeating_timer_event_table_top_defines.svh"
module rtet_ctrl
    import rtet_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [CMD_W-1:0] i_cmd,
    input  wire t_dp_stat         i_stat,
    output logic                  o_in_ready,
    output t_dp_cmd               o_ctl
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SUM1  = 5'd1;
    localparam logic [4:0] S_SUM2  = 5'd2;
    localparam logic [4:0] S_FREE  = 5'd3;
    localparam logic [4:0] S_ADDWR = 5'd4;
    localparam logic [4:0] S_RD    = 5'd5;
    localparam logic [4:0] S_CHK   = 5'd6;
    localparam logic [4:0] S_SETWR = 5'd7;
    localparam logic [4:0] S_CANC  = 5'd8;
    localparam logic [4:0] S_RUNT  = 5'd9;
    localparam logic [4:0] S_PRD   = 5'd10;
    localparam logic [4:0] S_PCHK  = 5'd11;
    localparam logic [4:0] S_SCLR  = 5'd12;
    localparam logic [4:0] S_SRD   = 5'd13;
    localparam logic [4:0] S_SCHK  = 5'd14;
    localparam logic [4:0] S_FCALC = 5'd15;
    localparam logic [4:0] S_FEMIT = 5'd16;
    localparam logic [4:0] S_FWR   = 5'd17;
    localparam logic [4:0] S_MISC  = 5'd18;
    localparam logic [4:0] S_EMIT  = 5'd19;

    logic [4:0]       r_state, n_state;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    t_op              r_emit, n_emit;
    t_op              op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= CMD_ADD_AT;
            r_emit  <= OP_EMIT_DONE;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
            r_emit  <= n_emit;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_emit  = r_emit;
        op      = OP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op    = OP_LOAD;
                    n_cmd = i_cmd;
                    case (i_cmd)
                        CMD_ADD_AT, CMD_ADD_NOW:   n_state = S_SUM1;
                        CMD_SET_IVL, CMD_CANCEL:   n_state = S_RD;
                        CMD_RUN_UNTIL, CMD_RUN_FOR: n_state = S_RUNT;
                        default:                   n_state = S_MISC;
                    endcase
                end
            end
            S_SUM1: begin
                op      = (r_cmd == CMD_ADD_AT) ? OP_SUM_TV : OP_SUM_CUR;
                n_state = S_SUM2;
            end
            S_SUM2: begin
                op      = OP_SUM_IVL;
                n_state = S_FREE;
            end
            S_FREE: begin
                op = OP_SCAN_FREE;
                if (i_stat.free_hit) begin
                    n_state = S_ADDWR;
                end else if (i_stat.last) begin
                    n_emit  = OP_EMIT_ADD_FULL;
                    n_state = S_EMIT;
                end
            end
            S_ADDWR: begin
                op      = OP_ADD_WR;
                n_emit  = OP_EMIT_ADD_OK;
                n_state = S_EMIT;
            end
            S_RD: begin
                op      = OP_RD;
                n_state = S_CHK;
            end
            S_CHK: begin
                op = OP_CHK_ID;
                if (i_stat.match) begin
                    n_state = (r_cmd == CMD_SET_IVL) ? S_SETWR : S_CANC;
                end else if (i_stat.last) begin
                    n_emit  = OP_EMIT_DONE;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_RD;
                end
            end
            S_SETWR: begin
                op      = OP_SET_WR;
                n_emit  = OP_EMIT_DONE;
                n_state = S_EMIT;
            end
            S_CANC: begin
                op      = OP_CANCEL;
                n_emit  = OP_EMIT_DONE;
                n_state = S_EMIT;
            end
            S_RUNT: begin
                op      = (r_cmd == CMD_RUN_UNTIL) ? OP_RUN_UNTIL : OP_RUN_FOR;
                n_state = S_PRD;
            end
            S_PRD: begin
                op      = OP_RD;
                n_state = S_PCHK;
            end
            S_PCHK: begin
                op      = OP_PEND_CHK;
                n_state = i_stat.last ? S_SCLR : S_PRD;
            end
            S_SCLR: begin
                op      = OP_SEL_CLR;
                n_state = S_SRD;
            end
            S_SRD: begin
                op      = OP_RD;
                n_state = S_SCHK;
            end
            S_SCHK: begin
                op = OP_SEL_CHK;
                if (!i_stat.last) begin
                    n_state = S_SRD;
                end else if (i_stat.found) begin
                    n_state = S_FCALC;
                end else begin
                    n_emit  = OP_EMIT_DONE;
                    n_state = S_EMIT;
                end
            end
            S_FCALC: begin
                op      = OP_FIRE_CALC;
                n_state = S_FEMIT;
            end
            S_FEMIT: begin
                if (!i_stat.out_busy) begin
                    op      = OP_EMIT_FIRE;
                    n_state = S_FWR;
                end
            end
            S_FWR: begin
                op      = OP_FIRE_WR;
                n_state = S_SCLR;
            end
            S_MISC: begin
                op      = (r_cmd == CMD_SET_TIME) ? OP_SET_TIME : OP_CLEAR;
                n_emit  = OP_EMIT_DONE;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    op      = r_emit;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_ctl.op   = op;

    `RTET_ASSERT_NXT(a_leave_idle, (r_state == S_IDLE) && i_in_valid,
        r_state != S_IDLE, "item accepted but controller stayed idle")
    `RTET_ASSERT_IMP(a_emit_free,
        (op == OP_EMIT_FIRE) || (op == OP_EMIT_DONE) ||
        (op == OP_EMIT_ADD_OK) || (op == OP_EMIT_ADD_FULL),
        !i_stat.out_busy, "result emitted over an untaken result")
endmodule
`default_nettype wire

>>> src/rtet_dp.sv
// Datapath of the timer table: slot RAM, valid and pending bits, scan index,
// saturating time arithmetic and the result register. Depends on rtet_pkg, rtet_ram and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "repeating_timer_event_table_top_defines.svh"
module rtet_dp
    import rtet_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_ctl,
    input  wire logic [ID_W-1:0]         i_event_id,
    input  wire logic [IO_TIME_W-1:0]    i_time_value,
    input  wire logic [IO_TIME_W-1:0]    i_delay,
    input  wire logic [IO_TIME_W-1:0]    i_interval,
    input  wire logic [REP_W-1:0]        i_repeat_count,
    input  wire logic                    i_out_ready,
    output t_dp_stat                     o_stat,
    output logic                         o_out_valid,
    output logic [KIND_W-1:0]            o_kind,
    output logic [ID_W-1:0]              o_timer_id,
    output logic                         o_success,
    output logic [REP_W-1:0]             o_repeats,
    output logic [IO_TIME_W-1:0]         o_period,
    output logic                         o_last
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EW = ID_W + 2 * TIME_BITS + REP_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                      input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

    logic [ID_W-1:0]          r_eid;
    logic [TIME_BITS-1:0]     r_tv, r_dl, r_iv, r_cur, r_acc;
    logic [REP_W-1:0]         r_rep;
    logic [ID_W-1:0]          r_idcnt;
    logic [IW-1:0]            r_idx, r_bidx;
    logic [SLOTS-1:0]         r_valid, r_pend;
    logic                     r_ok, r_found, r_ge;
    logic [TIME_BITS-1:0]     r_bexp, r_bper;
    logic [ID_W-1:0]          r_bid;
    logic [REP_W-1:0]         r_brep;
    logic                     r_ovalid;
    logic [KIND_W-1:0]        r_kind;
    logic [ID_W-1:0]          r_oid;
    logic                     r_osucc, r_olast;
    logic [REP_W-1:0]         r_orep;
    logic [IO_TIME_W-1:0]     r_oper;

    logic [EW-1:0]            rdata, wdata;
    logic                     we, re;
    logic [IW-1:0]            waddr;
    logic [ID_W-1:0]          rd_id;
    logic [TIME_BITS-1:0]     rd_exp, rd_per, set_exp;
    logic [REP_W-1:0]         rd_rep;
    logic                     cur_valid, better, sel_hit, rearm, is_emit;
    t_op                      op;

    assign op     = i_ctl.op;
    assign rd_id  = rdata[EW-1 -: ID_W];
    assign rd_exp = rdata[2*TIME_BITS+REP_W-1 -: TIME_BITS];
    assign rd_per = rdata[TIME_BITS+REP_W-1 -: TIME_BITS];
    assign rd_rep = rdata[REP_W-1:0];

    always_comb begin
        cur_valid = r_valid[r_idx];
        better    = !r_found || (rd_exp < r_bexp) || ((rd_exp == r_bexp) && (rd_id < r_bid));
        sel_hit   = r_pend[r_idx] && better;
        // forever timers and counts above one before this fire stay armed
        rearm     = r_brep[REP_W-1] || ($signed(r_brep) > $signed(REP_W'(1)));
        if (r_ge) begin
            set_exp = sat_add(rd_exp, r_acc);
        end else begin
            set_exp = (rd_exp > r_acc) ? (rd_exp - r_acc) : '0;
        end
        is_emit = (op == OP_EMIT_ADD_OK) || (op == OP_EMIT_ADD_FULL) ||
                  (op == OP_EMIT_FIRE) || (op == OP_EMIT_DONE);
    end

    assign o_stat.free_hit = !cur_valid;
    assign o_stat.last     = (r_idx == LAST_IDX);
    assign o_stat.match    = cur_valid && (rd_id == r_eid);
    assign o_stat.found    = r_found || sel_hit;
    assign o_stat.out_busy = r_ovalid && !i_out_ready;

    // RAM port control
    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = {r_idcnt + ID_W'(1), r_acc, r_iv, r_rep};
        re    = (op == OP_RD);
        case (op)
            OP_ADD_WR: we = 1'b1;
            OP_SET_WR: begin
                we    = 1'b1;
                wdata = {rd_id, set_exp, r_iv, rd_rep};
            end
            OP_FIRE_WR: begin
                we    = rearm;
                waddr = r_bidx;
                wdata = {r_bid, r_acc, r_bper,
                         r_brep[REP_W-1] ? r_brep : (r_brep - REP_W'(1))};
            end
            default: we = 1'b0;
        endcase
    end

    rtet_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    // control state: valid and pending bits, id counter, current time, scan index, flags, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_pend   <= '0;
            r_idcnt  <= '0;
            r_cur    <= '0;
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
            r_ok     <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (is_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (op)
                OP_LOAD: begin
                    r_idx <= '0;
                    r_ok  <= 1'b0;
                end
                OP_SCAN_FREE: begin
                    if (cur_valid) r_idx <= r_idx + IW'(1);
                end
                OP_ADD_WR: begin
                    r_valid[r_idx] <= 1'b1;
                    r_idcnt        <= r_idcnt + ID_W'(1);
                end
                OP_CHK_ID: begin
                    if (o_stat.match) r_ok <= 1'b1;
                    else              r_idx <= r_idx + IW'(1);
                end
                OP_CANCEL:    r_valid[r_idx] <= 1'b0;
                OP_RUN_UNTIL: begin
                    r_cur <= r_tv;
                    r_idx <= '0;
                end
                OP_RUN_FOR: begin
                    r_cur <= sat_add(r_cur, r_tv);
                    r_idx <= '0;
                end
                OP_PEND_CHK: begin
                    r_pend[r_idx] <= cur_valid && (rd_exp <= r_cur);
                    r_idx         <= r_idx + IW'(1);
                end
                OP_SEL_CLR: begin
                    r_found <= 1'b0;
                    r_idx   <= '0;
                end
                OP_SEL_CHK: begin
                    if (sel_hit) r_found <= 1'b1;
                    r_idx <= r_idx + IW'(1);
                end
                OP_FIRE_WR: begin
                    r_pend[r_bidx] <= 1'b0;
                    if (!rearm) r_valid[r_bidx] <= 1'b0;
                end
                OP_SET_TIME: r_cur   <= r_tv;
                OP_CLEAR:    r_valid <= '0;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (op)
            OP_LOAD: begin
                r_eid <= i_event_id;
                r_tv  <= TIME_BITS'(i_time_value);
                r_dl  <= TIME_BITS'(i_delay);
                r_iv  <= TIME_BITS'(i_interval);
                r_rep <= i_repeat_count;
            end
            OP_SUM_TV:  r_acc <= sat_add(r_tv, r_dl);
            OP_SUM_CUR: r_acc <= sat_add(r_cur, r_dl);
            OP_SUM_IVL: r_acc <= sat_add(r_acc, r_iv);
            OP_CHK_ID: begin
                if (o_stat.match) begin
                    r_ge  <= (r_iv >= rd_per);
                    r_acc <= (r_iv >= rd_per) ? (r_iv - rd_per) : (rd_per - r_iv);
                end
            end
            OP_SEL_CHK: begin
                if (sel_hit) begin
                    r_bidx <= r_idx;
                    r_bid  <= rd_id;
                    r_bexp <= rd_exp;
                    r_bper <= rd_per;
                    r_brep <= rd_rep;
                end
            end
            OP_FIRE_CALC: r_acc <= sat_add(r_cur, r_bper);
            OP_EMIT_ADD_OK: begin
                r_kind  <= KIND_ADD;
                r_oid   <= r_idcnt;
                r_osucc <= 1'b1;
                r_orep  <= '0;
                r_oper  <= '0;
                r_olast <= 1'b1;
            end
            OP_EMIT_ADD_FULL: begin
                r_kind  <= KIND_ADD;
                r_oid   <= '0;
                r_osucc <= 1'b0;
                r_orep  <= '0;
                r_oper  <= '0;
                r_olast <= 1'b1;
            end
            OP_EMIT_FIRE: begin
                r_kind  <= KIND_FIRE;
                r_oid   <= r_bid;
                r_osucc <= 1'b0;
                r_orep  <= r_brep;
                r_oper  <= IO_TIME_W'(r_bper);
                r_olast <= 1'b0;
            end
            OP_EMIT_DONE: begin
                r_kind  <= KIND_DONE;
                r_oid   <= '0;
                r_osucc <= r_ok;
                r_orep  <= '0;
                r_oper  <= '0;
                r_olast <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_kind      = r_kind;
    assign o_timer_id  = r_oid;
    assign o_success   = r_osucc;
    assign o_repeats   = r_orep;
    assign o_period    = r_oper;
    assign o_last      = r_olast;

    `RTET_ASSERT_IMP(a_add_free_slot, op == OP_ADD_WR, !r_valid[r_idx],
        "add writes an occupied slot")
    `RTET_ASSERT_IMP(a_fire_pending, op == OP_FIRE_WR,
        r_found && r_pend[r_bidx] && r_valid[r_bidx],
        "fire update on a slot that was not picked")
endmodule
`default_nettype wire

>>> src/repeating_timer_event_table_top.sv
// Top level of the repeating timer event table: stream ports, controller and datapath.
// Depends on rtet_pkg, rtet_ctrl, rtet_dp (and rtet_ram below it).
//
//  channel  | dir | tdata                                   | tuser | tlast
//  ---------+-----+-----------------------------------------+-------+------
//  s_axis   | in  | event_id, time_value, delay, interval,  | cmd   | -
//           |     | repeat_count (192 bits)                 |       |
//  m_axis   | out | timer_id, success, repeats, period (96) | kind  | last
//
// Per item (S = SLOTS): add scans for a free slot, set interval / cancel seek the id,
//   set time and clear do no scan; run scans all S slots for pending timers, then a
//   selection pass per fired timer and a final pass, on the one-read-per-cycle RAM.
// Reset is synchronous, active low; it clears all valid bits at once, no clearing pass.
// One item is worked at a time; the next is taken once its last result sits in the
//   output register. A stalled output holds the sequencer at its next result.
`timescale 1ns / 1ps
`default_nettype none
module repeating_timer_event_table_top
    import rtet_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [30:0] event_id, [78:31] time_value, [126:79] delay, [174:127] interval,
    // [190:175] repeat_count, [191] zero
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] cmd
    input  wire logic [CMD_W-1:0]      s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [30:0] timer_id, [31] success, [47:32] repeats_reported, [95:48] period_reported
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    // [1:0] kind
    output logic [KIND_W-1:0]          m_axis_tuser,
    output logic                       m_axis_tlast
);
    t_dp_cmd               ctl;
    t_dp_stat              stat;
    logic [ID_W-1:0]       out_id;
    logic                  out_succ;
    logic [REP_W-1:0]      out_rep;
    logic [IO_TIME_W-1:0]  out_per;

    rtet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_cmd      (s_axis_tuser),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_ctl      (ctl)
    );

    rtet_dp #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_event_id     (s_axis_tdata[30:0]),
        .i_time_value   (s_axis_tdata[78:31]),
        .i_delay        (s_axis_tdata[126:79]),
        .i_interval     (s_axis_tdata[174:127]),
        .i_repeat_count (s_axis_tdata[190:175]),
        .i_out_ready    (m_axis_tready),
        .o_stat         (stat),
        .o_out_valid    (m_axis_tvalid),
        .o_kind         (m_axis_tuser),
        .o_timer_id     (out_id),
        .o_success      (out_succ),
        .o_repeats      (out_rep),
        .o_period       (out_per),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {out_per, out_rep, out_succ, out_id};
endmodule
`default_nettype wire

>>> sim/repeating_timer_event_table_checker.sv
// Scoreboard for the repeating timer event table: watches both stream channels,
// predicts every result from the accepted commands and compares. Depends on rtet_pkg.
`timescale 1ns / 1ps
module repeating_timer_event_table_checker
    import rtet_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic [CMD_W-1:0]      i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_TDATA_W-1:0]  i_m_tdata,
    input  logic [KIND_W-1:0]     i_m_tuser,
    input  logic                  i_m_tlast,
    output int                    o_fail_count,
    output int                    o_outstanding,
    output int                    o_fire_count,
    output int                    o_full_count
);
    localparam logic [47:0] T_MAX = {48{1'b1}};

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   tid;
        logic              ok;
        logic [REP_W-1:0]  reps;
        logic [47:0]       period;
        logic              last;
    } t_result;

    // timer table mirror
    logic                     tm_live   [SLOTS];
    logic [ID_W-1:0]          tm_id     [SLOTS];
    logic [47:0]              tm_expire [SLOTS];
    logic [47:0]              tm_period [SLOTS];
    logic signed [REP_W-1:0]  tm_reps   [SLOTS];
    logic [ID_W-1:0]          next_id;
    logic [47:0]              now_time;

    t_result expected_results[$];

    function automatic logic [47:0] tsum(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? T_MAX : s[47:0];
    endfunction

    function automatic t_result mk(logic [KIND_W-1:0] k, logic [ID_W-1:0] id, logic ok,
                                   logic [REP_W-1:0] r, logic [47:0] p, logic l);
        t_result x;
        x.kind = k; x.tid = id; x.ok = ok; x.reps = r; x.period = p; x.last = l;
        return x;
    endfunction

    function automatic int lookup(logic [ID_W-1:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (tm_live[i] && tm_id[i] == id) return i;
        return -1;
    endfunction

    // fire every timer due at t, earliest expiration first, ties by id then slot
    task automatic fire_due(logic [47:0] t);
        logic due[SLOTS];
        int   b;
        now_time = t;
        for (int i = 0; i < SLOTS; i++) due[i] = tm_live[i] && tm_expire[i] <= t;
        forever begin
            b = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!due[i]) continue;
                if (b < 0 || tm_expire[i] < tm_expire[b] ||
                    (tm_expire[i] == tm_expire[b] && tm_id[i] < tm_id[b]))
                    b = i;
            end
            if (b < 0) break;
            due[b] = 1'b0;
            o_fire_count++;
            expected_results.push_back(mk(KIND_FIRE, tm_id[b], 1'b0, tm_reps[b],
                                          tm_period[b], 1'b0));
            if (tm_reps[b] < 0) begin
                tm_expire[b] = tsum(t, tm_period[b]);
            end else begin
                tm_reps[b] = tm_reps[b] - 1;
                if (tm_reps[b] > 0) tm_expire[b] = tsum(t, tm_period[b]);
                else tm_live[b] = 1'b0;
            end
        end
        expected_results.push_back(mk(KIND_DONE, '0, 1'b0, '0, '0, 1'b1));
    endtask

    task automatic predict_command(logic [CMD_W-1:0] cmd, logic [S_TDATA_W-1:0] d);
        logic [ID_W-1:0]  eid;
        logic [47:0]      tv, dl, iv, base, old;
        logic [REP_W-1:0] rep;
        int               s;
        eid = d[30:0];
        tv  = d[78:31];
        dl  = d[126:79];
        iv  = d[174:127];
        rep = d[190:175];
        case (cmd)
            CMD_ADD_AT, CMD_ADD_NOW: begin
                base = (cmd == CMD_ADD_AT) ? tv : now_time;
                s = -1;
                for (int i = SLOTS - 1; i >= 0; i--) if (!tm_live[i]) s = i;
                if (s < 0) begin
                    o_full_count++;
                    expected_results.push_back(mk(KIND_ADD, '0, 1'b0, '0, '0, 1'b1));
                end else begin
                    next_id = next_id + 1'b1;
                    tm_live[s] = 1'b1;
                    tm_id[s] = next_id;
                    tm_expire[s] = tsum(tsum(base, dl), iv);
                    tm_period[s] = iv;
                    tm_reps[s] = rep;
                    expected_results.push_back(mk(KIND_ADD, next_id, 1'b1, '0, '0, 1'b1));
                end
            end
            CMD_SET_IVL: begin
                s = lookup(eid);
                if (s >= 0) begin
                    old = tm_period[s];
                    if (iv >= old) tm_expire[s] = tsum(tm_expire[s], iv - old);
                    else if (tm_expire[s] > old - iv) tm_expire[s] = tm_expire[s] - (old - iv);
                    else tm_expire[s] = '0;
                    tm_period[s] = iv;
                end
                expected_results.push_back(mk(KIND_DONE, '0, s >= 0, '0, '0, 1'b1));
            end
            CMD_CANCEL: begin
                s = lookup(eid);
                if (s >= 0) tm_live[s] = 1'b0;
                expected_results.push_back(mk(KIND_DONE, '0, s >= 0, '0, '0, 1'b1));
            end
            CMD_RUN_UNTIL: fire_due(tv);
            CMD_RUN_FOR:   fire_due(tsum(now_time, tv));
            CMD_SET_TIME: begin
                now_time = tv;
                expected_results.push_back(mk(KIND_DONE, '0, 1'b0, '0, '0, 1'b1));
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) tm_live[i] = 1'b0;
                expected_results.push_back(mk(KIND_DONE, '0, 1'b0, '0, '0, 1'b1));
            end
        endcase
    endtask

    initial begin
        o_fail_count = 0;
        o_fire_count = 0;
        o_full_count = 0;
        next_id = '0;
        now_time = '0;
        for (int i = 0; i < SLOTS; i++) tm_live[i] = 1'b0;
    end

    assign o_outstanding = expected_results.size();

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                got = mk(i_m_tuser, i_m_tdata[30:0], i_m_tdata[31], i_m_tdata[47:32],
                         i_m_tdata[95:48], i_m_tlast);
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result %p", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        $display("%0t: result mismatch expected %p actual %p",
                                 $time, want, got);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) predict_command(i_s_tuser, i_s_tdata);
        end
    end
endmodule

>>> sim/repeating_timer_event_table_top_tb.sv
// Testbench top for the repeating timer event table: clock, reset, command stimulus,
// result back-pressure and verdict. Depends on rtet_pkg and the checker module.
`timescale 1ns / 1ps
module repeating_timer_event_table_top_tb;
    import rtet_pkg::*;

    localparam int          SLOTS       = 16;
    localparam int          RANDOM_CMDS = 300;
    localparam int          CYCLE_LIMIT = 1500000;
    localparam logic [47:0] T_MAX       = {48{1'b1}};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // id, time, delay, interval, repeats, pad
    logic [CMD_W-1:0]     s_axis_tuser;   // cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // id, success, repeats, period
    logic [KIND_W-1:0]    m_axis_tuser;   // kind
    logic                 m_axis_tlast;

    int fail_count, outstanding, fire_count, full_count;
    int cycles;
    int adds_sent;          // upper bound on ids handed out so far
    int cmds_sent;          // commands taken by the block
    logic [47:0] now_guess; // stimulus-side view of current time

    repeating_timer_event_table_top i_dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
    );

    repeating_timer_event_table_checker #(.SLOTS(SLOTS)) i_checker (
        .i_clk, .i_rst_n,
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tuser(m_axis_tuser), .i_m_tlast(m_axis_tlast),
        .o_fail_count(fail_count), .o_outstanding(outstanding),
        .o_fire_count(fire_count), .o_full_count(full_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL repeating_timer_event_table_top");
            $finish;
        end
    end

    // result back-pressure: mostly ready, short stalls, the odd long one,
    // and quiet stretches with no stall at all
    int stall_left = 0;
    int calm_left  = 0;
    initial m_axis_tready = 1'b0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (calm_left > 0) begin
            calm_left <= calm_left - 1;
            m_axis_tready <= 1'b1;
        end else begin
            case ($urandom_range(0, 19))
                0:       stall_left <= $urandom_range(10, 40);
                1:       calm_left  <= $urandom_range(50, 300);
                2, 3, 4: stall_left <= $urandom_range(0, 3);
                default: ;
            endcase
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    function automatic logic [47:0] tsum(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? T_MAX : s[47:0];
    endfunction

    // hand one command to the block and hold it until taken, then maybe idle
    task automatic issue_cmd(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] eid, logic [47:0] tv,
                             logic [47:0] dl, logic [47:0] iv, logic [REP_W-1:0] rep);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, rep, iv, dl, tv, eid};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        cmds_sent++;
        if (cmd == CMD_ADD_AT || cmd == CMD_ADD_NOW) adds_sent++;
        if (cmd == CMD_RUN_UNTIL || cmd == CMD_SET_TIME) now_guess = tv;
        if (cmd == CMD_RUN_FOR) now_guess = tsum(now_guess, tv);
        case ($urandom_range(0, 9))
            0:       gap = $urandom_range(15, 60);
            1, 2, 3: gap = $urandom_range(1, 4);
            default: gap = 0;
        endcase
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // pick an id near recently allocated ones, so lookups mostly hit
    function automatic logic [ID_W-1:0] near_id();
        int lo;
        lo = (adds_sent > 20) ? adds_sent - 20 : 0;
        return ID_W'($urandom_range(lo, adds_sent + 1));
    endfunction

    function automatic logic [REP_W-1:0] pick_reps();
        case ($urandom_range(0, 9))
            0, 1:    return '1;                        // forever
            2:       return REP_W'($urandom_range(0, 32767));
            default: return REP_W'($urandom_range(0, 4));
        endcase
    endfunction

    initial begin
        logic [CMD_W-1:0] c;
        int               pick;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_ADD_AT;
        i_rst_n       = 1'b0;
        adds_sent     = 0;
        cmds_sent     = 0;
        now_guess     = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: saturation on add, zero and forever repeats, a full table,
        // interval grow and shrink (down to zero), missing ids, each run form, clear
        issue_cmd(CMD_ADD_AT, '1, T_MAX, T_MAX, T_MAX, 16'h7fff);
        issue_cmd(CMD_ADD_NOW, '0, '0, 48'd0, 48'd0, 16'd0);
        issue_cmd(CMD_ADD_NOW, '0, '0, 48'd3, 48'd5, '1);
        issue_cmd(CMD_ADD_AT, '0, 48'd2, 48'd1, 48'd100, 16'd2);
        repeat (13) issue_cmd(CMD_ADD_NOW, '0, '0, 48'd4, 48'd7, 16'd3);
        issue_cmd(CMD_SET_IVL, 31'd3, '0, '0, 48'd200, '0);
        issue_cmd(CMD_SET_IVL, 31'd4, '0, '0, 48'd0, '0);
        issue_cmd(CMD_SET_IVL, '1, '0, '0, 48'd1, '0);
        issue_cmd(CMD_CANCEL, 31'd1, '0, '0, '0, '0);
        issue_cmd(CMD_CANCEL, 31'h7fff_fff0, '0, '0, '0, '0);
        issue_cmd(CMD_RUN_UNTIL, '0, 48'd20, '0, '0, '0);
        issue_cmd(CMD_RUN_FOR, '0, 48'd40, '0, '0, '0);
        issue_cmd(CMD_SET_TIME, '0, T_MAX - 48'd2, '0, '0, '0);
        issue_cmd(CMD_RUN_FOR, '0, T_MAX, '0, '0, '0);
        issue_cmd(CMD_CLEAR, '0, '0, '0, '0, '0);
        issue_cmd(CMD_SET_TIME, '0, 48'd0, '0, '0, '0);

        // random: mostly sane timer traffic around the current time, some noise
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                c = CMD_W'($urandom_range(0, 7));
                issue_cmd(c, ID_W'($urandom), 48'({$urandom, $urandom}),
                          48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                          REP_W'($urandom));
                if (c == CMD_SET_TIME || c == CMD_RUN_UNTIL || c == CMD_RUN_FOR)
                    issue_cmd(CMD_SET_TIME, '0, 48'($urandom_range(0, 1000)), '0, '0, '0);
            end else if (pick < 35)
                issue_cmd(CMD_ADD_NOW, ID_W'($urandom), 48'({$urandom, $urandom}),
                          48'($urandom_range(0, 30)), 48'($urandom_range(0, 40)), pick_reps());
            else if (pick < 45)
                issue_cmd(CMD_ADD_AT, ID_W'($urandom),
                          tsum(now_guess, 48'($urandom_range(0, 20))),
                          48'($urandom_range(0, 30)), 48'($urandom_range(0, 40)), pick_reps());
            else if (pick < 70)
                issue_cmd(CMD_RUN_FOR, ID_W'($urandom), 48'($urandom_range(0, 40)),
                          48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                          REP_W'($urandom));
            else if (pick < 75)
                issue_cmd(CMD_RUN_UNTIL, '0, tsum(now_guess, 48'($urandom_range(0, 60))),
                          '0, '0, '0);
            else if (pick < 85)
                issue_cmd(CMD_SET_IVL, near_id(), '0, '0, 48'($urandom_range(0, 60)), '0);
            else if (pick < 94)
                issue_cmd(CMD_CANCEL, near_id(), '0, '0, '0, '0);
            else if (pick < 97)
                issue_cmd(CMD_SET_TIME, '0, 48'($urandom_range(0, 5000)), '0, '0, '0);
            else
                issue_cmd(CMD_CLEAR, '0, '0, '0, '0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Ran %0d commands (%0d adds); %0d timer fires and %0d full-table adds checked.",
                 cmds_sent, adds_sent, fire_count, full_count);
        if (fail_count == 0)
            $display("PASS repeating_timer_event_table_top");
        else
            $display("FAIL repeating_timer_event_table_top");
        $finish;
    end
endmodule

>>> repeating_timer_event_table_top.f
+incdir+src
src/rtet_pkg.sv
src/rtet_ram.sv
src/rtet_ctrl.sv
src/rtet_dp.sv
src/repeating_timer_event_table_top.sv
sim/repeating_timer_event_table_checker.sv
sim/repeating_timer_event_table_top_tb.sv
